### src/tvs_pkg.sv
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared types and constants for the trilinear volume sampler.
// ----------------------------------------------------------------------------
package tvs_pkg;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_SIZE_I  = 3'd0,
        REG_SIZE_J  = 3'd1,
        REG_SIZE_K  = 3'd2,
        REG_INV_I   = 3'd3,
        REG_INV_J   = 3'd4,
        REG_INV_K   = 3'd5
    } t_reg_idx;

    localparam logic [5:0]  SIZE_RESET = 6'd32;
    localparam logic [23:0] INV_RESET  = 24'd65536;

    // Request: one write or one query
    typedef struct packed {
        logic               kind;
        logic [4:0]         index_i;
        logic [4:0]         index_j;
        logic [4:0]         index_k;
        logic signed [23:0] sample_value;
        logic [31:0]        coord_i;
        logic [31:0]        coord_j;
        logic [31:0]        coord_k;
    } t_in_req;

    // Result of one query
    typedef struct packed {
        logic signed [23:0] interp_value;
        logic               out_of_bounds;
    } t_out_rsp;

endpackage

### src/tvs_ram.sv
// ----------------------------------------------------------------------------
// tvs_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tvs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/trilinear_volume_sampler.sv
// ----------------------------------------------------------------------------
// trilinear_volume_sampler
// Trilinear interpolation over a 3D grid of signed fixed-point samples.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------
//   in      | input     | i_in_valid / o_in_stall   | t_in_req
//   out     | output    | o_out_valid / i_out_stall | t_out_rsp
//   cfg     | input     | APB psel/penable/pwrite   | 32-bit data
//
// One request per cycle is taken while o_in_stall is low; a query result passes
// the request, scaling, bank and blend stages to the output register. The grid
// sits in eight parity banks (one per corner parity), so all eight neighbours
// are read in the same cycle. Reset clears control and configuration only; grid
// contents are undefined until written. A stalled output holds in the output
// register, one more result goes to a skid register, then the input is stalled.
// ----------------------------------------------------------------------------
module trilinear_volume_sampler
    import tvs_pkg::*;
#(
    parameter int GRID_MAX    = 32,
    parameter int SAMPLE_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_req     i_in_req,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_rsp    o_out_rsp,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SB   = SAMPLE_BITS;
    localparam int RW   = SB + 18;
    localparam int MW   = (SB > 24) ? SB : 24;
    localparam int HALF = (GRID_MAX + 1) / 2;
    localparam int BD   = HALF * HALF * HALF;
    localparam int BAW  = (BD > 1) ? $clog2(BD) : 1;
    localparam logic [9:0] GMAX10 = 10'(GRID_MAX);

    typedef logic signed [SB-1:0] t_smp;
    typedef logic signed [RW-1:0] t_acc;

    // bank address from three grid indexes
    function automatic logic [BAW-1:0] bank_addr(input logic [8:0] a,
                                                 input logic [8:0] b,
                                                 input logic [8:0] c);
        logic [31:0] t;
        t = ((32'(a[8:1]) * 32'(HALF)) + 32'(b[8:1])) * 32'(HALF) + 32'(c[8:1]);
        return BAW'(t);
    endfunction

    // round half up and drop the 16 weight bits
    function automatic t_smp round16(input t_smp a, input t_acc p);
        t_acc t;
        t = (RW'(a) <<< 16) + p + RW'(32768);
        return t[SB+15:16];
    endfunction

    // (b - a) * f
    function automatic t_acc lerp_prod(input t_smp a, input t_smp b,
                                       input logic [15:0] f);
        logic signed [SB:0] d;
        logic signed [16:0] fs;
        d  = (SB+1)'(b) - (SB+1)'(a);
        fs = {1'b0, f};
        return RW'(d) * RW'(fs);
    endfunction

    // ---------------- configuration registers ----------------
    logic [5:0]  r_size [3];
    logic [23:0] r_inv  [3];
    logic        cfg_we;
    t_reg_idx    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_size[a] <= SIZE_RESET;
                r_inv[a]  <= INV_RESET;
            end
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_SIZE_I: r_size[0] <= pwdata[5:0];
                REG_SIZE_J: r_size[1] <= pwdata[5:0];
                REG_SIZE_K: r_size[2] <= pwdata[5:0];
                REG_INV_I:  r_inv[0]  <= pwdata[23:0];
                REG_INV_J:  r_inv[1]  <= pwdata[23:0];
                REG_INV_K:  r_inv[2]  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SIZE_I: prdata = {26'd0, r_size[0]};
            REG_SIZE_J: prdata = {26'd0, r_size[1]};
            REG_SIZE_K: prdata = {26'd0, r_size[2]};
            REG_INV_I:  prdata = {8'd0, r_inv[0]};
            REG_INV_J:  prdata = {8'd0, r_inv[1]};
            REG_INV_K:  prdata = {8'd0, r_inv[2]};
            default:    prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic r_skid_valid;
    logic en;
    logic in_acc;

    assign en         = !r_skid_valid;
    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid && !o_in_stall;

    // stage 1: request register
    logic    r1_v;
    t_in_req r1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1 <= i_in_req;
        end
    end

    // stage 2: scale coordinates to grid units
    logic        r2_v;
    logic        r2_kind;
    logic [4:0]  r2_widx [3];
    t_smp        r2_wdata;
    logic [55:0] r2_g    [3];
    logic [31:0] coord   [3];
    logic [MW-1:0] wide_in;

    assign coord[0] = r1.coord_i;
    assign coord[1] = r1.coord_j;
    assign coord[2] = r1.coord_k;
    assign wide_in  = MW'(unsigned'(r1.sample_value));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_kind    <= r1.kind;
            r2_widx[0] <= r1.index_i;
            r2_widx[1] <= r1.index_j;
            r2_widx[2] <= r1.index_k;
            r2_wdata   <= wide_in[SB-1:0];
            for (int a = 0; a < 3; a++) begin
                r2_g[a] <= 56'(coord[a]) * 56'(r_inv[a]);
            end
        end
    end

    // stage 3: bounds, neighbour indexes, bank access
    logic [8:0]  nm1   [3];
    logic [8:0]  lo    [3];
    logic [8:0]  hi    [3];
    logic [15:0] frac  [3];
    logic        nz    [3];
    logic        oob;
    logic        wr_ok;
    logic        wr_en;
    logic [2:0]  wr_bank;
    logic [BAW-1:0] wr_addr;
    logic [BAW-1:0] rd_addr [8];
    logic [8:0]  sel   [3];
    t_smp        rd    [8];

    always_comb begin
        oob = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (r_size[a] == 6'd0) begin
                nm1[a] = 9'd0;
            end else if (10'(r_size[a]) > GMAX10) begin
                nm1[a] = 9'(GMAX10 - 10'd1);
            end else begin
                nm1[a] = 9'(r_size[a]) - 9'd1;
            end
            if ((r2_g[a][55:32] > 24'(nm1[a])) ||
                ((r2_g[a][55:32] == 24'(nm1[a])) && (r2_g[a][31:0] != 32'd0))) begin
                oob = 1'b1;
            end
            lo[a]   = r2_g[a][40:32];
            frac[a] = r2_g[a][31:16];
            nz[a]   = (frac[a] != 16'd0);
            hi[a]   = nz[a] ? lo[a] + 9'd1 : lo[a];
        end
    end

    // per bank: pick the neighbour of matching parity on each axis
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            for (int a = 0; a < 3; a++) begin
                sel[a] = (lo[a][0] == b[2-a]) ? lo[a] : hi[a];
            end
            rd_addr[b] = bank_addr(sel[0], sel[1], sel[2]);
        end
    end

    assign wr_ok   = (10'(r2_widx[0]) < GMAX10) && (10'(r2_widx[1]) < GMAX10) &&
                     (10'(r2_widx[2]) < GMAX10);
    assign wr_en   = en && r2_v && (r2_kind == KIND_WRITE) && wr_ok;
    assign wr_bank = {r2_widx[0][0], r2_widx[1][0], r2_widx[2][0]};
    assign wr_addr = bank_addr(9'(r2_widx[0]), 9'(r2_widx[1]), 9'(r2_widx[2]));

    for (genvar b = 0; b < 8; b++) begin : g_bank
        logic [SB-1:0] rdata;
        tvs_ram #(
            .WIDTH (SB),
            .DEPTH (BD)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (wr_en && (wr_bank == 3'(b))),
            .i_waddr (wr_addr),
            .i_wdata (r2_wdata),
            .i_re    (en),
            .i_raddr (rd_addr[b]),
            .o_rdata (rdata)
        );
        assign rd[b] = rdata;
    end

    logic        r3_v;
    logic        r3_oob;
    logic [15:0] r3_f   [3];
    logic        r3_lob [3];
    logic        r3_nz  [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v && (r2_kind == KIND_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_oob <= oob;
            for (int a = 0; a < 3; a++) begin
                r3_f[a]   <= frac[a];
                r3_lob[a] <= lo[a][0];
                r3_nz[a]  <= nz[a];
            end
        end
    end

    // stage 4: corner select and blend along i
    t_smp corner_lo [4];
    t_smp corner_hi [4];

    always_comb begin
        for (int m = 0; m < 4; m++) begin
            corner_lo[m] = rd[{r3_lob[0], r3_lob[1] ^ (m[1] & r3_nz[1]),
                               r3_lob[2] ^ (m[0] & r3_nz[2])}];
            corner_hi[m] = rd[{r3_lob[0] ^ r3_nz[0], r3_lob[1] ^ (m[1] & r3_nz[1]),
                               r3_lob[2] ^ (m[0] & r3_nz[2])}];
        end
    end

    logic        r4_v;
    logic        r4_oob;
    logic [15:0] r4_fj;
    logic [15:0] r4_fk;
    t_smp        r4_a [4];
    t_acc        r4_p [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_oob <= r3_oob;
            r4_fj  <= r3_f[1];
            r4_fk  <= r3_f[2];
            for (int m = 0; m < 4; m++) begin
                r4_a[m] <= corner_lo[m];
                r4_p[m] <= lerp_prod(corner_lo[m], corner_hi[m], r3_f[0]);
            end
        end
    end

    // stage 5: round i blends
    logic        r5_v;
    logic        r5_oob;
    logic [15:0] r5_fj;
    logic [15:0] r5_fk;
    t_smp        r5_c [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_oob <= r4_oob;
            r5_fj  <= r4_fj;
            r5_fk  <= r4_fk;
            for (int m = 0; m < 4; m++) begin
                r5_c[m] <= round16(r4_a[m], r4_p[m]);
            end
        end
    end

    // stage 6: blend along j
    logic        r6_v;
    logic        r6_oob;
    logic [15:0] r6_fk;
    t_smp        r6_a [2];
    t_acc        r6_p [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_oob <= r5_oob;
            r6_fk  <= r5_fk;
            for (int m = 0; m < 2; m++) begin
                r6_a[m] <= r5_c[m];
                r6_p[m] <= lerp_prod(r5_c[m], r5_c[m+2], r5_fj);
            end
        end
    end

    // stage 7: round j blends
    logic        r7_v;
    logic        r7_oob;
    logic [15:0] r7_fk;
    t_smp        r7_c [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_oob  <= r6_oob;
            r7_fk   <= r6_fk;
            r7_c[0] <= round16(r6_a[0], r6_p[0]);
            r7_c[1] <= round16(r6_a[1], r6_p[1]);
        end
    end

    // stage 8: blend along k
    logic r8_v;
    logic r8_oob;
    t_smp r8_a;
    t_acc r8_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_oob <= r7_oob;
            r8_a   <= r7_c[0];
            r8_p   <= lerp_prod(r7_c[0], r7_c[1], r7_fk);
        end
    end

    // final rounding; a convex blend stays inside the sample range
    t_smp          v_fin;
    logic signed [MW-1:0] v_wide;
    t_out_rsp      rsp_fin;

    assign v_fin  = round16(r8_a, r8_p);
    assign v_wide = MW'(v_fin);

    always_comb begin
        rsp_fin.out_of_bounds = r8_oob;
        rsp_fin.interp_value  = r8_oob ? 24'sd0 : v_wide[23:0];
    end

    // ---------------- output register and skid ----------------
    logic     r_out_valid;
    t_out_rsp r_out;
    t_out_rsp r_skid;
    logic     out_take;
    logic     out_free;

    assign out_take = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || out_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (r8_v) begin
            if (out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out <= r_skid;
            end
        end else if (r8_v) begin
            if (out_free) begin
                r_out <= rsp_fin;
            end else begin
                r_skid <= rsp_fin;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trilinear volume sampler. A directed table
// covers the extremes first. Random phases then follow under several grid
// sizes and reciprocal spacings. Each query result is compared field by field
// with the table's expected value or the bench's own interpolated prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import tvs_pkg::*;

    localparam int GRID      = 32;
    localparam int LATENCY   = 12;
    localparam int WDOG_MAX  = 4000;
    localparam int REG_SPARE = 6;   // first address past the register list

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_req     i_in_req;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_rsp    o_out_rsp;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;

    trilinear_volume_sampler u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_rsp  (o_out_rsp),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Bench copy of the grid and the registers
    logic signed [23:0] grid_mem [GRID*GRID*GRID];
    bit                 grid_written [GRID*GRID*GRID];
    logic [5:0]         grid_size [3];
    logic [23:0]        inv_step [3];

    t_out_rsp sample_q [$];
    int       n_errors;
    bit       quiet;

    typedef struct {
        t_in_req  req;
        bit       typed;
        t_out_rsp rsp;
    } t_row;
    t_row stim_table [$];

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int cell_addr(input int i, input int j, input int k);
        return (i * GRID + j) * GRID + k;
    endfunction

    function automatic int eff_size(input logic [5:0] s);
        if (s == 0) return 1;
        if (s > GRID) return GRID;
        return int'(s);
    endfunction

    // Map one coordinate to grid units: lower/upper neighbour and weight
    function automatic bit map_axis(input logic [31:0] c, input int ax,
                                    output int lo, output int hi, output int f);
        logic [63:0] g;
        logic [63:0] lim;
        g   = 64'(c) * 64'(inv_step[ax]);
        lim = 64'(eff_size(grid_size[ax]) - 1) << 32;
        if (g > lim) return 1'b0;
        lo = int'(g[63:32]);
        f  = int'(g[31:16]);
        hi = (f != 0) ? lo + 1 : lo;
        return 1'b1;
    endfunction

    // One lerp stage, rounding half up
    function automatic longint lerp_q16(input longint a, input longint b, input int f);
        longint r;
        r = a * (65536 - f) + b * f;
        return (r + 32768) >>> 16;
    endfunction

    // True when a query would touch no unwritten grid entry
    function automatic bit query_safe(input t_in_req r);
        int i0, i1, j0, j1, k0, k1, fi, fj, fk;
        if (!(map_axis(r.coord_i, 0, i0, i1, fi) && map_axis(r.coord_j, 1, j0, j1, fj)
              && map_axis(r.coord_k, 2, k0, k1, fk)))
            return 1'b1;
        foreach (grid_written[n]) ;
        return grid_written[cell_addr(i0, j0, k0)] && grid_written[cell_addr(i1, j0, k0)]
            && grid_written[cell_addr(i0, j0, k1)] && grid_written[cell_addr(i1, j0, k1)]
            && grid_written[cell_addr(i0, j1, k0)] && grid_written[cell_addr(i1, j1, k0)]
            && grid_written[cell_addr(i0, j1, k1)] && grid_written[cell_addr(i1, j1, k1)];
    endfunction

    // Apply one request to the bench grid; returns 1 when a result is due
    function automatic bit interpolate(input t_in_req r, output t_out_rsp o);
        int     i0, i1, j0, j1, k0, k1, fi, fj, fk;
        longint c00, c01, c10, c11, c0, c1, v;
        if (r.kind == KIND_WRITE) begin
            grid_mem[cell_addr(r.index_i, r.index_j, r.index_k)]     = r.sample_value;
            grid_written[cell_addr(r.index_i, r.index_j, r.index_k)] = 1'b1;
            return 1'b0;
        end
        if (!(map_axis(r.coord_i, 0, i0, i1, fi) && map_axis(r.coord_j, 1, j0, j1, fj)
              && map_axis(r.coord_k, 2, k0, k1, fk))) begin
            o.interp_value  = '0;
            o.out_of_bounds = 1'b1;
            return 1'b1;
        end
        c00 = lerp_q16(grid_mem[cell_addr(i0, j0, k0)], grid_mem[cell_addr(i1, j0, k0)], fi);
        c01 = lerp_q16(grid_mem[cell_addr(i0, j0, k1)], grid_mem[cell_addr(i1, j0, k1)], fi);
        c10 = lerp_q16(grid_mem[cell_addr(i0, j1, k0)], grid_mem[cell_addr(i1, j1, k0)], fi);
        c11 = lerp_q16(grid_mem[cell_addr(i0, j1, k1)], grid_mem[cell_addr(i1, j1, k1)], fi);
        c0  = lerp_q16(c00, c10, fj);
        c1  = lerp_q16(c01, c11, fj);
        v   = lerp_q16(c0, c1, fk);
        if (v > 64'sd8388607) v = 64'sd8388607;
        if (v < -64'sd8388608) v = -64'sd8388608;
        o.interp_value  = v[23:0];
        o.out_of_bounds = 1'b0;
        return 1'b1;
    endfunction

    function automatic t_in_req mk_write(input int i, input int j, input int k,
                                         input logic [23:0] v);
        t_in_req r;
        r = '0;
        r.kind = KIND_WRITE;
        r.index_i = 5'(i);
        r.index_j = 5'(j);
        r.index_k = 5'(k);
        r.sample_value = v;
        return r;
    endfunction

    function automatic t_in_req mk_query(input logic [31:0] ci, input logic [31:0] cj,
                                         input logic [31:0] ck);
        t_in_req r;
        r = '0;
        r.kind = KIND_QUERY;
        r.coord_i = ci;
        r.coord_j = cj;
        r.coord_k = ck;
        return r;
    endfunction

    // Coordinate aimed at the filled corner of the grid on one axis
    function automatic logic [31:0] aim_coord(input int ax);
        int          n;
        logic [63:0] mx;
        n  = eff_size(grid_size[ax]);
        n  = (n < 4) ? n : 4;
        mx = (inv_step[ax] == 0) ? 64'hFFFF_FFFF : (64'(n - 1) << 32) / 64'(inv_step[ax]);
        if (mx > 64'hFFFF_FFFF) mx = 64'hFFFF_FFFF;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return mx[31:0];
            default: return 32'({$urandom(), $urandom()} % (mx + 1));
        endcase
    endfunction

    // Send one request, then predict it once accepted
    task automatic send_req(input t_in_req r, input bit typed, input t_out_rsp e);
        t_out_rsp p;
        int       gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (interpolate(r, p)) sample_q.push_back(typed ? e : p);
    endtask

    // Wait for all results, then let the pipe run dry
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic cfg_write(input int idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SIZE_I: grid_size[0] = val[5:0];
            REG_SIZE_J: grid_size[1] = val[5:0];
            REG_SIZE_K: grid_size[2] = val[5:0];
            REG_INV_I:  inv_step[0]  = val[23:0];
            REG_INV_J:  inv_step[1]  = val[23:0];
            REG_INV_K:  inv_step[2]  = val[23:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [5:0] si, input logic [5:0] sj, input logic [5:0] sk,
                            input logic [23:0] vi, input logic [23:0] vj,
                            input logic [23:0] vk);
        cfg_write(REG_SIZE_I, 32'(si));
        cfg_write(REG_SIZE_J, 32'(sj));
        cfg_write(REG_SIZE_K, 32'(sk));
        cfg_write(REG_INV_I, 32'(vi));
        cfg_write(REG_INV_J, 32'(vj));
        cfg_write(REG_INV_K, 32'(vk));
    endtask

    task automatic add_row(input t_in_req r, input bit typed, input logic [23:0] v,
                           input logic oob);
        t_row w;
        w.req = r;
        w.typed = typed;
        w.rsp.interp_value = v;
        w.rsp.out_of_bounds = oob;
        stim_table.push_back(w);
    endtask

    // Result checker and output stall bursts
    initial begin
        int stall_left;
        stall_left  = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                if (sample_q.size() == 0) begin
                    $error("unexpected result: interp_value %0d", o_out_rsp.interp_value);
                    n_errors++;
                end else begin
                    t_out_rsp e;
                    e = sample_q.pop_front();
                    if (o_out_rsp.interp_value !== e.interp_value) begin
                        $error("interp_value: expected %0d, got %0d",
                               e.interp_value, o_out_rsp.interp_value);
                        n_errors++;
                    end
                    if (o_out_rsp.out_of_bounds !== e.out_of_bounds) begin
                        $error("out_of_bounds: expected %0b, got %0b",
                               e.out_of_bounds, o_out_rsp.out_of_bounds);
                        n_errors++;
                    end
                end
            end
            if (stall_left > 0) stall_left--;
            else if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 8);
            i_out_stall <= (stall_left > 0);
        end
    end

    // Watchdog on cycles with no traffic at all
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
                idle = 0;
            else
                idle++;
            if (idle >= WDOG_MAX) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        t_in_req  r;
        t_out_rsp none;
        int       tries, pick;
        n_errors   = 0;
        quiet      = 1'b0;
        none       = '0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_req   <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        for (int a = 0; a < 3; a++) begin
            grid_size[a] = SIZE_RESET;
            inv_step[a]  = INV_RESET;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under reset settings
        add_row(mk_write(0, 0, 0, 24'h7FFFFF), 0, 0, 0);
        add_row(mk_write(1, 0, 0, 24'h800000), 0, 0, 0);
        add_row(mk_write(31, 31, 31, 24'hFFFFFF), 0, 0, 0);
        add_row(mk_write(0, 0, 1, 24'h000000), 0, 0, 0);
        add_row(mk_write(1, 0, 1, 24'h123456), 0, 0, 0);
        add_row(mk_query(0, 0, 0), 1, 24'h7FFFFF, 0);
        add_row(mk_query(31 << 16, 31 << 16, 31 << 16), 1, 24'hFFFFFF, 0);
        add_row(mk_query(32 << 16, 0, 0), 1, 0, 1);
        add_row(mk_query(0, 32'hFFFF_FFFF, 0), 1, 0, 1);
        add_row(mk_query(0, 0, 32'hFFFF_FFFF), 1, 0, 1);
        add_row(mk_query(32'h8000, 0, 0), 0, 0, 0);
        add_row(mk_query(32'h8000, 0, 32'h4000), 0, 0, 0);
        add_row(mk_query(32'hFFFF, 0, 32'h1), 0, 0, 0);
        add_row(mk_write(31, 31, 31, 24'h000000), 0, 0, 0);
        add_row(mk_query(31 << 16, 31 << 16, 31 << 16), 1, 24'h000000, 0);
        foreach (stim_table[n])
            send_req(stim_table[n].req, stim_table[n].typed, stim_table[n].rsp);

        // Random phases, each under its own grid setting
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: set_grid(2, 2, 2, 1, 1, 1);
                1: set_grid(0, 63, 2, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
                2: set_grid(32, 32, 32, 24'hFFFFFF, 1, 65536);
                5: set_grid(32, 32, 32, 65536, 65536, 65536);
                default: set_grid(6'($urandom_range(2, 32)), 6'($urandom_range(2, 32)),
                                  6'($urandom_range(2, 32)), 24'($urandom_range(1, 24'hFFFFFF)),
                                  24'($urandom_range(1, 24'h3FFFF)),
                                  24'($urandom_range(16384, 24'h2FFFF)));
            endcase
            if (ph == 2) cfg_write(REG_SPARE, 32'hFFFF_FFFF);
            if (ph == 5) quiet = 1'b1;
            // Fill the low corner that aimed queries land in
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    for (int k = 0; k < 4; k++)
                        send_req(mk_write(i, j, k, 24'($urandom)), 0, none);
            for (int n = 0; n < 225; n++) begin
                pick = $urandom_range(0, 19);
                if (pick < 3) begin
                    r = mk_write($urandom_range(0, 31), $urandom_range(0, 31),
                                 $urandom_range(0, 31), 24'($urandom));
                end else begin
                    tries = 0;
                    do begin
                        if (pick < 6)
                            r = mk_query($urandom, $urandom, $urandom);
                        else
                            r = mk_query(aim_coord(0), aim_coord(1), aim_coord(2));
                        tries++;
                    end while (!query_safe(r) && tries < 20);
                    if (!query_safe(r))
                        r = mk_write($urandom_range(0, 3), $urandom_range(0, 3),
                                     $urandom_range(0, 3), 24'($urandom));
                end
                send_req(r, 0, none);
            end
        end

        // Wind down
        i_in_valid <= 1'b0;
        while (sample_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
